@@ rtl/usr_pkg.sv @@
`default_nettype none

package usr_pkg;

  // Counter width of the tick and echo-width counters
  localparam int COUNT_WIDTH = 16;
  localparam int CFG_W       = 16;
  localparam int TRIG_W      = 8;
  localparam int DIST_W      = 17;
  localparam int CMP_W       = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  localparam int DIST_MUL_W  = 11;
  localparam int PROD_W      = COUNT_WIDTH + DIST_MUL_W;
  localparam int DQ_W        = (PROD_W - 8 > DIST_W) ? PROD_W - 8 : DIST_W;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [DIST_MUL_W-1:0]  DIST_MUL  = 11'd1114;
  localparam logic [DIST_W-1:0]      DIST_MAX  = 17'd111390;

  localparam logic [TRIG_W-1:0] TRIG_RST    = 8'd10;
  localparam logic [CFG_W-1:0]  TIMEOUT_RST = 16'd20000;
  localparam logic [CFG_W-1:0]  MIN_RST     = 16'd118;
  localparam logic [CFG_W-1:0]  MAX_RST     = 16'd23529;
  localparam logic [CFG_W-1:0]  STOP_RST    = 16'd1176;

  localparam logic [2:0] REG_TRIGGER = 3'd0;
  localparam logic [2:0] REG_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_MIN     = 3'd2;
  localparam logic [2:0] REG_MAX     = 3'd3;
  localparam logic [2:0] REG_STOP    = 3'd4;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_MEAS = 2'd3
  } phase_t;

endpackage

`default_nettype wire

@@ rtl/ultrasonic_ranger_with_safety_stop.sv @@
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// in       | input     | in_valid/in_stall  | func, echo_level
// out      | output    | out_valid/out_stall| trigger_level .. stop_request
// cfg      | input     | cfg_write          | cfg_index, cfg_data
//
// One item per cycle sustained while the result is not stalled; an item passes from
// the input register to the result (state update and result register).
// The state update, including the width*1114 multiply, is combinational logic.
// Synchronous reset returns to idle with registers at their defaults.
// A stalled result holds one item in the input register before in_stall rises.

module ultrasonic_ranger_with_safety_stop
  import usr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        func,
  input  wire logic              echo_level,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   trigger_level,
  output logic                   busy_res,
  output logic                   done_res,
  output logic                   range_valid,
  output logic [DIST_W-1:0]      distance_cm_q8,
  output logic                   obstacle_latch,
  output logic                   stop_request,
  input  wire logic              cfg_write,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  logic [TRIG_W-1:0] trigger_ticks;
  logic [CFG_W-1:0]  echo_timeout_ticks;
  logic [CFG_W-1:0]  min_echo_ticks;
  logic [CFG_W-1:0]  max_echo_ticks;
  logic [CFG_W-1:0]  stop_echo_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_ticks      <= TRIG_RST;
      echo_timeout_ticks <= TIMEOUT_RST;
      min_echo_ticks     <= MIN_RST;
      max_echo_ticks     <= MAX_RST;
      stop_echo_ticks    <= STOP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TRIGGER: trigger_ticks      <= cfg_data[TRIG_W-1:0];
        REG_TIMEOUT: echo_timeout_ticks <= cfg_data;
        REG_MIN:     min_echo_ticks     <= cfg_data;
        REG_MAX:     max_echo_ticks     <= cfg_data;
        REG_STOP:    stop_echo_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic       in_full;
  logic [1:0] func_q;
  logic       echo_q;
  logic       advance;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_q <= func;
      echo_q <= echo_level;
    end
  end

  // measurement state
  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [COUNT_WIDTH-1:0] echo_width, echo_width_next;
  logic [DIST_W-1:0]      last_distance, last_distance_next;
  logic                   last_valid, last_valid_next;
  logic                   override_flag, override_flag_next;

  logic [COUNT_WIDTH-1:0] tick_inc, width_inc;
  logic                   trig_end, wait_end, meas_end;
  logic                   finish, wait_timeout;
  logic [COUNT_WIDTH-1:0] fin_w;
  logic [PROD_W-1:0]      prod;
  logic [DQ_W-1:0]        dq;
  logic [DIST_W-1:0]      dist_sat;
  logic                   w_valid, w_stop;

  assign tick_inc  = (tick_count == COUNT_MAX) ? COUNT_MAX : tick_count + 1'b1;
  assign width_inc = (echo_width == COUNT_MAX) ? COUNT_MAX : echo_width + 1'b1;

  assign trig_end = (CMP_W'(tick_inc) >= CMP_W'(trigger_ticks)) || (tick_inc == COUNT_MAX);
  assign wait_end = (CMP_W'(tick_inc) >= CMP_W'(echo_timeout_ticks))
                    || (tick_inc == COUNT_MAX);
  assign meas_end = (CMP_W'(width_inc) >= CMP_W'(echo_timeout_ticks))
                    || (width_inc == COUNT_MAX);

  always_comb begin
    finish       = 1'b0;
    wait_timeout = 1'b0;
    fin_w        = echo_q ? width_inc : echo_width;
    if (func_q == FUNC_TICK) begin
      if (phase == PH_WAIT && !echo_q && wait_end) begin
        wait_timeout = 1'b1;
      end
      if (phase == PH_MEAS && (!echo_q || meas_end)) begin
        finish = 1'b1;
      end
    end
  end

  assign prod     = PROD_W'(fin_w) * PROD_W'(DIST_MUL);
  assign dq       = DQ_W'(prod >> 8);
  assign dist_sat = (dq > DQ_W'(DIST_MAX)) ? DIST_MAX : dq[DIST_W-1:0];
  assign w_valid  = (CMP_W'(fin_w) >= CMP_W'(min_echo_ticks))
                    && (CMP_W'(fin_w) <= CMP_W'(max_echo_ticks));
  assign w_stop   = w_valid && (CMP_W'(fin_w) <= CMP_W'(stop_echo_ticks));

  // next state
  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    echo_width_next = echo_width;
    unique case (func_q)
      FUNC_START: begin
        if (phase == PH_IDLE) begin
          phase_next      = PH_TRIG;
          tick_count_next = '0;
          echo_width_next = '0;
        end
      end
      FUNC_TICK: begin
        unique case (phase)
          PH_TRIG: begin
            tick_count_next = trig_end ? '0 : tick_inc;
            if (trig_end) phase_next = PH_WAIT;
          end
          PH_WAIT: begin
            if (echo_q) begin
              phase_next      = PH_MEAS;
              echo_width_next = COUNT_WIDTH'(1);
              tick_count_next = '0;
            end else begin
              tick_count_next = tick_inc;
              if (wait_end) phase_next = PH_IDLE;
            end
          end
          PH_MEAS: begin
            if (echo_q) echo_width_next = width_inc;
            if (finish) phase_next = PH_IDLE;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // result fields and latched status
  always_comb begin
    last_distance_next = last_distance;
    last_valid_next    = last_valid;
    override_flag_next = override_flag;
    if (func_q == FUNC_CLEAR) begin
      override_flag_next = 1'b0;
    end
    if (wait_timeout) begin
      last_distance_next = '0;
      last_valid_next    = 1'b0;
    end
    if (finish) begin
      last_distance_next = dist_sat;
      last_valid_next    = w_valid;
      if (w_stop) override_flag_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      echo_width    <= '0;
      last_distance <= '0;
      last_valid    <= 1'b0;
      override_flag <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      echo_width    <= echo_width_next;
      last_distance <= last_distance_next;
      last_valid    <= last_valid_next;
      override_flag <= override_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      trigger_level  <= (phase_next == PH_TRIG);
      busy_res       <= (phase_next != PH_IDLE);
      done_res       <= finish || wait_timeout;
      range_valid    <= last_valid_next;
      distance_cm_q8 <= last_distance_next;
      obstacle_latch <= override_flag_next;
      stop_request   <= finish && w_stop;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  a_stop_latched: assert property (@(posedge clk) disable iff (rst)
    out_valid && stop_request |-> obstacle_latch && range_valid && done_res)
    else $error("stop request without a valid close measurement");

  a_trig_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && trigger_level |-> busy_res && !done_res)
    else $error("trigger high outside a measurement");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full && out_valid && out_stall)
    else $error("input held without a blocked result");

endmodule

`default_nettype wire

@@ verif/ultrasonic_ranger_with_safety_stop_test.sv @@
`timescale 1ns / 1ps

module ultrasonic_ranger_with_safety_stop_test;
  import usr_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 150;
  localparam int RANDOM_ITEMS = 400;

  typedef struct packed {
    logic              trig;
    logic              busy;
    logic              done;
    logic              ok;
    logic [DIST_W-1:0] cm_q8;
    logic              ovr;
    logic              stop;
  } range_res_t;

  typedef struct packed {
    logic [1:0] f;
    logic       e;
    logic       chk;
    range_res_t res;
  } dir_row_t;

  localparam range_res_t NO_RES = '0;

  // Directed rows, run with trigger 2, timeout 3, min 1, max 2, stop 1.
  localparam dir_row_t DIR_TAB [24] = '{
    '{FUNC_TICK,   1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 17'd0,  1'b0, 1'b0}},
    '{FUNC_UNUSED, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 17'd0,  1'b0, 1'b0}},
    '{FUNC_CLEAR,  1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 17'd0,  1'b0, 1'b0}},
    '{FUNC_START,  1'b0, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 17'd0,  1'b0, 1'b0}},
    '{FUNC_START,  1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 17'd0,  1'b0, 1'b0}},
    '{FUNC_TICK,   1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 17'd0,  1'b0, 1'b0}},
    '{FUNC_TICK,   1'b0, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 17'd0,  1'b0, 1'b0}},
    '{FUNC_TICK,   1'b0, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 17'd0,  1'b0, 1'b0}},
    '{FUNC_TICK,   1'b0, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 17'd0,  1'b0, 1'b0}},
    // no echo rise in time
    '{FUNC_TICK,   1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 17'd0,  1'b0, 1'b0}},
    '{FUNC_START,  1'b0, 1'b0, NO_RES},
    '{FUNC_TICK,   1'b1, 1'b0, NO_RES},
    '{FUNC_TICK,   1'b1, 1'b0, NO_RES},
    '{FUNC_TICK,   1'b1, 1'b0, NO_RES},
    '{FUNC_CLEAR,  1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 17'd0,  1'b0, 1'b0}},
    // one-tick echo inside stop distance
    '{FUNC_TICK,   1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, 17'd4,  1'b1, 1'b1}},
    '{FUNC_TICK,   1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 17'd4,  1'b1, 1'b0}},
    '{FUNC_START,  1'b1, 1'b0, NO_RES},
    '{FUNC_TICK,   1'b0, 1'b0, NO_RES},
    '{FUNC_TICK,   1'b0, 1'b0, NO_RES},
    '{FUNC_TICK,   1'b1, 1'b0, NO_RES},
    '{FUNC_TICK,   1'b1, 1'b0, NO_RES},
    // echo still high at the timeout: width 3 is over the maximum
    '{FUNC_TICK,   1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 17'd13, 1'b1, 1'b0}},
    '{FUNC_CLEAR,  1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 17'd13, 1'b0, 1'b0}}
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        func;
  logic              echo_level;
  logic              out_valid;
  logic              out_stall;
  logic              trigger_level;
  logic              busy_res;
  logic              done_res;
  logic              range_valid;
  logic [DIST_W-1:0] distance_cm_q8;
  logic              obstacle_latch;
  logic              stop_request;
  logic              cfg_write;
  logic [2:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  // predictor state and register shadow
  phase_t                 ph;
  logic [COUNT_WIDTH-1:0] tick_cnt;
  logic [COUNT_WIDTH-1:0] echo_w;
  logic [DIST_W-1:0]      last_dist;
  logic                   last_ok;
  logic                   ovr;
  logic [TRIG_W-1:0]      reg_trig;
  logic [CFG_W-1:0]       reg_timeout;
  logic [CFG_W-1:0]       reg_min;
  logic [CFG_W-1:0]       reg_max;
  logic [CFG_W-1:0]       reg_stop;

  range_res_t pending_ranges[$];
  int         n_errors = 0;
  int         n_items = 0;
  int         n_settings = 0;
  int         n_done = 0;
  int         n_stop = 0;
  bit         no_idle = 1'b0;
  bit         hold_req = 1'b0;

  ultrasonic_ranger_with_safety_stop u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .echo_level      (echo_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .trigger_level   (trigger_level),
    .busy_res        (busy_res),
    .done_res        (done_res),
    .range_valid     (range_valid),
    .distance_cm_q8  (distance_cm_q8),
    .obstacle_latch  (obstacle_latch),
    .stop_request    (stop_request),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  // Judge a finished echo width; returns the stop pulse.
  function automatic logic close_echo(input logic [COUNT_WIDTH-1:0] w);
    logic [31:0] prod;
    prod = 32'(w) * 32'(DIST_MUL);
    prod = prod >> 8;
    last_dist = (prod > 32'(DIST_MAX)) ? DIST_MAX : prod[DIST_W-1:0];
    last_ok = (w >= reg_min) && (w <= reg_max);
    if (last_ok && w <= reg_stop) begin
      ovr = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic range_res_t range_step(input logic [1:0] f, input logic e);
    range_res_t r;
    r = '0;
    case (f)
      FUNC_START: begin
        if (ph == PH_IDLE) begin
          ph = PH_TRIG;
          tick_cnt = '0;
          echo_w = '0;
        end
      end
      FUNC_CLEAR: ovr = 1'b0;
      FUNC_TICK: begin
        case (ph)
          PH_TRIG: begin
            tick_cnt = bump(tick_cnt);
            if (tick_cnt >= reg_trig || tick_cnt == COUNT_MAX) begin
              ph = PH_WAIT;
              tick_cnt = '0;
            end
          end
          PH_WAIT: begin
            if (e) begin
              ph = PH_MEAS;
              echo_w = COUNT_WIDTH'(1);
              tick_cnt = '0;
            end else begin
              tick_cnt = bump(tick_cnt);
              if (tick_cnt >= reg_timeout || tick_cnt == COUNT_MAX) begin
                ph = PH_IDLE;
                last_ok = 1'b0;
                last_dist = '0;
                r.done = 1'b1;
              end
            end
          end
          PH_MEAS: begin
            if (!e) begin
              ph = PH_IDLE;
              r.stop = close_echo(echo_w);
              r.done = 1'b1;
            end else begin
              echo_w = bump(echo_w);
              if (echo_w >= reg_timeout || echo_w == COUNT_MAX) begin
                ph = PH_IDLE;
                r.stop = close_echo(echo_w);
                r.done = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.trig = (ph == PH_TRIG);
    r.busy = (ph != PH_IDLE);
    r.ok = last_ok;
    r.cm_q8 = last_dist;
    r.ovr = ovr;
    return r;
  endfunction

  // Offer one item and hold it until the transfer; a typed expectation
  // replaces the predicted one where given.
  task automatic send_item(input logic [1:0] f, input logic e,
                           input logic typed = 1'b0, input range_res_t want = '0);
    range_res_t r;
    if (!no_idle && $urandom_range(99) < 2) begin
      @(negedge clk);
      in_valid <= 1'b0;
      func <= 2'($urandom_range(3));
      echo_level <= 1'($urandom_range(1));
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    func <= f;
    echo_level <= e;
    do @(posedge clk); while (in_stall);
    r = range_step(f, e);
    pending_ranges.push_back(typed ? want : r);
    n_items++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_ranges.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_TRIGGER: reg_trig = val[TRIG_W-1:0];
      REG_TIMEOUT: reg_timeout = val;
      REG_MIN:     reg_min = val;
      REG_MAX:     reg_max = val;
      REG_STOP:    reg_stop = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input int t, input int tmo, input int mn, input int mx,
                              input int st);
    wait_drained();
    write_reg(REG_TRIGGER, CFG_W'(t));
    write_reg(REG_TIMEOUT, CFG_W'(tmo));
    write_reg(REG_MIN, CFG_W'(mn));
    write_reg(REG_MAX, CFG_W'(mx));
    write_reg(REG_STOP, CFG_W'(st));
    n_settings++;
  endtask

  // One ranging cycle: start, trigger, wait for the echo, echo pulse.
  // Widths sit mostly on the programmed boundaries.
  task automatic run_ranging();
    int n_trig, n_wait, width;
    if ($urandom_range(99) < 25)
      repeat ($urandom_range(1, 3)) send_item(2'($urandom_range(3)), 1'($urandom_range(1)));
    send_item(FUNC_START, 1'($urandom_range(1)));
    n_trig = (reg_trig == 0) ? 1 : int'(reg_trig);
    repeat (n_trig) begin
      if ($urandom_range(99) < 8)
        send_item(2'($urandom_range(1, 3)), 1'($urandom_range(1)));
      send_item(FUNC_TICK, 1'($urandom_range(1)));
    end
    n_wait = ($urandom_range(99) < 15) ? int'(reg_timeout) : $urandom_range(0, 4);
    if (n_wait > 250) n_wait = $urandom_range(0, 4);
    repeat (n_wait) send_item(FUNC_TICK, 1'b0);
    case ($urandom_range(9))
      0: width = int'(reg_min) - 1;
      1: width = int'(reg_min);
      2: width = int'(reg_min) + 1;
      3: width = int'(reg_stop);
      4: width = int'(reg_stop) + 1;
      5: width = int'(reg_max);
      6: width = int'(reg_max) + 1;
      7: width = int'(reg_timeout);
      8: width = int'(reg_timeout) + 1;
      default: width = $urandom_range(1, 40);
    endcase
    if (width < 1) width = 1;
    if (width > 250) width = $urandom_range(1, 250);
    repeat (width) begin
      if ($urandom_range(99) < 3) send_item(FUNC_CLEAR, 1'b1);
      send_item(FUNC_TICK, 1'b1);
    end
    send_item(FUNC_TICK, 1'b0);
  endtask

  initial begin : rx_side
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold-off so the block backs up onto its input
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(99) < 2) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : res_check
    range_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_ranges.size() == 0) begin
        $error("result transfer with nothing expected");
        n_errors++;
      end else begin
        want = pending_ranges.pop_front();
        if (trigger_level !== want.trig) begin
          $error("trigger_level expected %0d got %0d", want.trig, trigger_level);
          n_errors++;
        end
        if (busy_res !== want.busy) begin
          $error("busy_res expected %0d got %0d", want.busy, busy_res);
          n_errors++;
        end
        if (done_res !== want.done) begin
          $error("done_res expected %0d got %0d", want.done, done_res);
          n_errors++;
        end
        if (range_valid !== want.ok) begin
          $error("range_valid expected %0d got %0d", want.ok, range_valid);
          n_errors++;
        end
        if (distance_cm_q8 !== want.cm_q8) begin
          $error("distance_cm_q8 expected %0d got %0d", want.cm_q8, distance_cm_q8);
          n_errors++;
        end
        if (obstacle_latch !== want.ovr) begin
          $error("obstacle_latch expected %0d got %0d", want.ovr, obstacle_latch);
          n_errors++;
        end
        if (stop_request !== want.stop) begin
          $error("stop_request expected %0d got %0d", want.stop, stop_request);
          n_errors++;
        end
        if (want.done) n_done++;
        if (want.stop) n_stop++;
      end
    end
  end

  initial begin : stimulus
    int budget, rand_base, mn;
    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_TICK;
    echo_level = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_TRIGGER;
    cfg_data = '0;
    ph = PH_IDLE;
    tick_cnt = '0;
    echo_w = '0;
    last_dist = '0;
    last_ok = 1'b0;
    ovr = 1'b0;
    reg_trig = TRIG_RST;
    reg_timeout = TIMEOUT_RST;
    reg_min = MIN_RST;
    reg_max = MAX_RST;
    reg_stop = STOP_RST;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    program_regs(2, 3, 1, 2, 1);
    foreach (DIR_TAB[i])
      send_item(DIR_TAB[i].f, DIR_TAB[i].e, DIR_TAB[i].chk, DIR_TAB[i].res);

    // zero limits: every count ends on its first tick
    program_regs(0, 0, 0, 0, 0);
    budget = n_items + 60;
    while (n_items < budget) run_ranging();

    program_regs(3, 40, 5, 30, 12);
    run_ranging();
    hold_req = 1'b1;
    budget = n_items + 150;
    while (n_items < budget) run_ranging();

    // reset defaults, both sides flat out
    program_regs(TRIG_RST, TIMEOUT_RST, MIN_RST, MAX_RST, STOP_RST);
    no_idle = 1'b1;
    budget = n_items + 80;
    while (n_items < budget) run_ranging();
    no_idle = 1'b0;

    rand_base = n_items;
    while (n_items - rand_base < RANDOM_ITEMS) begin
      mn = $urandom_range(0, 40);
      program_regs($urandom_range(0, 20), $urandom_range(0, 200), mn,
                   ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(mn, 160),
                   $urandom_range(0, 120));
      budget = n_items + 80;
      while (n_items < budget) begin
        run_ranging();
        if ($urandom_range(99) < 5) wait_drained();
      end
    end

    wait_drained();
    repeat (6) @(posedge clk);
    $display("Run covered %0d transfers under %0d register settings,", n_items, n_settings);
    $display("with %0d ranges finished and %0d stop requests raised.", n_done, n_stop);
    if (n_errors == 0) begin
      $display("PASS ultrasonic_ranger_with_safety_stop");
    end else begin
      $display("FAIL ultrasonic_ranger_with_safety_stop");
    end
    $finish;
  end

  initial begin : watchdog
    #(1_000_000);
    $display("FAIL ultrasonic_ranger_with_safety_stop");
    $finish;
  end

endmodule
